/* hdl/sem_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// shared constants and types of the rgb sobel edge magnitude block
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W     = 11;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int GRAD_W    = 12;
    localparam int SUM_W     = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [CH_W-1:0]  t_chan;

    typedef struct packed {
        logic start;
        t_sum s_red;
        t_sum s_green;
        t_sum s_blue;
    } t_root_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_chan n_red;
        t_chan n_green;
        t_chan n_blue;
    } t_root_stat;

endpackage

/* hdl/sem_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem interfaces
// pixel input, edge result output and register write channels
// ----------------------------------------------------------------------------
interface sem_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, operation, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface sem_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       last_pixel;
    modport source (output valid, red_edge, green_edge, blue_edge, last_pixel, input ready);
    modport sink   (input valid, red_edge, green_edge, blue_edge, last_pixel, output ready);
endinterface

interface sem_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sem_pkg::CFG_IDX_W-1:0] index;
    logic [sem_pkg::DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/sem_root.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_root
// rounded square root of three sums, one result bit per cycle
// ----------------------------------------------------------------------------
module sem_root (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sem_pkg::t_root_req i_req,
    output sem_pkg::t_root_stat o_stat
);

    logic                r_busy;
    logic                r_done;
    logic [2:0]          r_bit;
    sem_pkg::t_sum       r_s [3];
    sem_pkg::t_chan      r_n [3];
    sem_pkg::t_chan      n_n [3];

    // greedy bit search for the largest n with n*n-n below s
    always_comb begin
        logic [7:0]  cand;
        logic [15:0] sq;
        logic [16:0] f;
        for (int c = 0; c < 3; c++) begin
            cand = r_n[c] | (8'd1 << r_bit);
            sq   = cand * cand;
            f    = {1'b0, sq} - {9'd0, cand};
            n_n[c] = ({4'd0, f} < r_s[c]) ? cand : r_n[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= 3'd7;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_bit  <= 3'd7;
            end else if (r_busy) begin
                r_bit <= r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_s[0] <= i_req.s_red;
            r_s[1] <= i_req.s_green;
            r_s[2] <= i_req.s_blue;
            for (int c = 0; c < 3; c++) r_n[c] <= '0;
        end else if (r_busy) begin
            for (int c = 0; c < 3; c++) r_n[c] <= n_n[c];
        end
    end

    assign o_stat.busy    = r_busy;
    assign o_stat.done    = r_done;
    assign o_stat.n_red   = r_n[0];
    assign o_stat.n_green = r_n[1];
    assign o_stat.n_blue  = r_n[2];

endmodule

/* hdl/sobel_edge_magnitude_rgb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top
// streaming 3x3 sobel gradient magnitude per color channel, two-row line memory
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  i_in      in   operation, red_in, green_in, blue_in
//  o_out     out  red_edge, green_edge, blue_edge, last_pixel
//  i_cfg     in   index (0 width, 1 height), data
//
//  one item at a time: an item with no result passes the read and window states;
//  an item with a result also passes gradient, square, start, the 8-step
//  bit-serial root unit and output, waiting while the result register is full.
//  the line memory is one read and one write per item at the item's column.
//  reset is synchronous and clears position counters and handshake state.
//  the result register lets the next item start while a result waits.
//  register writes are taken only while no item is in flight.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sem_in_if.sink    i_in,
    sem_out_if.source o_out,
    sem_cfg_if.sink   i_cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_WIN  = 3'd2;
    localparam logic [2:0] S_GRAD = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;
    localparam logic [2:0] S_STRT = 3'd5;
    localparam logic [2:0] S_ROOT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam int CW = sem_pkg::COL_W;
    localparam int DW = sem_pkg::DIM_W;
    localparam int GW = sem_pkg::GRAD_W;

    logic [2:0]            r_state, n_state;
    logic [DW-1:0]         r_width, r_height;
    logic [DW-1:0]         r_row;
    logic [CW-1:0]         r_col;
    sem_pkg::t_pixel       r_cur;
    sem_pkg::t_pixel       r_win [3][3];
    logic [2*sem_pkg::PIX_W-1:0] r_mem_q;
    logic [2*sem_pkg::PIX_W-1:0] mem [sem_pkg::MAX_WIDTH];
    logic signed [GW-1:0]  r_gx [3];
    logic signed [GW-1:0]  r_gy [3];
    logic signed [GW-1:0]  n_gx [3];
    logic signed [GW-1:0]  n_gy [3];
    sem_pkg::t_sum         r_sq [3];
    logic                  r_last;
    logic                  r_out_valid;
    logic [7:0]            r_out_r, r_out_g, r_out_b;
    logic                  r_out_last;

    logic [DW-1:0]         w, h;
    logic [DW-1:0]         cr;
    logic [CW-1:0]         cc;
    logic                  emit, last;
    logic                  in_acc, cfg_acc, out_free, advance;
    logic [DW-1:0]         col_inc;
    sem_pkg::t_root_req    root_req;
    sem_pkg::t_root_stat   root_stat;

    // effective frame size
    always_comb begin
        priority if (r_width == '0) w = DW'(1);
        else if (r_width > sem_pkg::DIM_MAX_W) w = sem_pkg::DIM_MAX_W;
        else w = r_width;
        priority if (r_height == '0) h = DW'(1);
        else if (r_height > sem_pkg::DIM_MAX_H) h = sem_pkg::DIM_MAX_H;
        else h = r_height;
    end

    // centre pixel of the current item
    always_comb begin
        emit = (r_row >= DW'(2)) || (r_row == DW'(1) && r_col != '0);
        if (r_col != '0) begin
            cr = r_row - DW'(1);
            cc = r_col - CW'(1);
        end else begin
            cr = r_row - DW'(2);
            cc = CW'(w - DW'(1));
        end
        last    = (cr == h - DW'(1)) && ({1'b0, cc} == w - DW'(1));
        col_inc = {1'b0, r_col} + DW'(1);
    end

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = (r_state == S_WIN && !emit) || (r_state == S_OUT && out_free);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_READ;
            S_READ: n_state = S_WIN;
            S_WIN:  n_state = emit ? S_GRAD : S_IDLE;
            S_GRAD: n_state = S_SQ;
            S_SQ:   n_state = S_STRT;
            S_STRT: n_state = S_ROOT;
            S_ROOT: if (root_stat.done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= sem_pkg::DIM_MAX_W;
            r_height <= sem_pkg::DIM_MAX_H;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_acc && (i_cfg.index == sem_pkg::REG_WIDTH ||
                            i_cfg.index == sem_pkg::REG_HEIGHT)) begin
                if (i_cfg.index == sem_pkg::REG_WIDTH) r_width <= i_cfg.data;
                else r_height <= i_cfg.data;
                r_row <= '0;
                r_col <= '0;
            end else if (advance) begin
                priority if (emit && last) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (col_inc >= w) begin
                    r_row <= r_row + DW'(1);
                    r_col <= '0;
                end else begin
                    r_col <= CW'(col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur <= i_in.operation ? '0 : {i_in.red_in, i_in.green_in, i_in.blue_in};
        end
    end

    // line memory: upper half two rows back, lower half one row back
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) r_mem_q <= mem[r_col];
        if (r_state == S_WIN) mem[r_col] <= {r_mem_q[sem_pkg::PIX_W-1:0], r_cur};
    end

    // window columns oldest to newest, rows top to bottom
    always_ff @(posedge i_clk) begin
        if (r_state == S_WIN) begin
            for (int r = 0; r < 3; r++) begin
                r_win[0][r] <= r_win[1][r];
                r_win[1][r] <= r_win[2][r];
            end
            r_win[2][0] <= r_mem_q[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
            r_win[2][1] <= r_mem_q[sem_pkg::PIX_W-1:0];
            r_win[2][2] <= r_cur;
            r_last      <= last;
        end
    end

    always_comb begin
        logic signed [GW-1:0] p [3][3];
        logic                 ok;
        for (int ch = 0; ch < 3; ch++) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    ok = !(r == 0 && cr == '0) && !(r == 2 && cr == h - DW'(1)) &&
                         !(c == 0 && cc == '0) &&
                         !(c == 2 && {1'b0, cc} == w - DW'(1));
                    p[c][r] = ok ? GW'({4'd0, r_win[c][r][(2-ch)*8 +: 8]}) : '0;
                end
            end
            n_gx[ch] = (p[2][0] - p[0][0]) + ((p[2][1] - p[0][1]) <<< 1) +
                       (p[2][2] - p[0][2]);
            n_gy[ch] = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) +
                       (p[2][2] - p[2][0]);
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [2*GW-1:0] qx, qy;
        if (r_state == S_GRAD) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_gx[ch] <= n_gx[ch];
                r_gy[ch] <= n_gy[ch];
            end
        end
        if (r_state == S_SQ) begin
            for (int ch = 0; ch < 3; ch++) begin
                qx = r_gx[ch] * r_gx[ch];
                qy = r_gy[ch] * r_gy[ch];
                r_sq[ch] <= sem_pkg::SUM_W'(qx) + sem_pkg::SUM_W'(qy);
            end
        end
    end

    assign root_req.start   = (r_state == S_STRT);
    assign root_req.s_red   = r_sq[0];
    assign root_req.s_green = r_sq[1];
    assign root_req.s_blue  = r_sq[2];

    sem_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_stat  (root_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_r    <= root_stat.n_red;
            r_out_g    <= root_stat.n_green;
            r_out_b    <= root_stat.n_blue;
            r_out_last <= r_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.red_edge   = r_out_r;
    assign o_out.green_edge = r_out_g;
    assign o_out.blue_edge  = r_out_b;
    assign o_out.last_pixel = r_out_last;

endmodule

/* bench/sobel_edge_magnitude_rgb_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top_test
// drives rgb frames with flush items through the edge block, predicts every
// edge magnitude from a behavioral line history and checks each result item
// ----------------------------------------------------------------------------
class edge_scoreboard;
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_edge;

    localparam int HIST_N = 2 * sem_pkg::MAX_WIDTH + 2;

    bit [23:0]               history[HIST_N];
    int                      row, col;
    bit [sem_pkg::DIM_W-1:0] width_reg, height_reg;
    t_edge                   expected_edges[$];
    int                      errors, results_seen;

    function new();
        row = 0;
        col = 0;
        width_reg = sem_pkg::DIM_W'(1024);
        height_reg = sem_pkg::DIM_W'(1024);
        errors = 0;
        results_seen = 0;
    endfunction

    task report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function void write_reg(logic [sem_pkg::CFG_IDX_W-1:0] idx,
                            logic [sem_pkg::DIM_W-1:0] data);
        if (idx == sem_pkg::REG_WIDTH) begin
            width_reg = data;
        end else if (idx == sem_pkg::REG_HEIGHT) begin
            height_reg = data;
        end else begin
            return;
        end
        row = 0;
        col = 0;
    endfunction

    function int clamp_dim(int v, int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function logic [7:0] rounded_root(int s);
        if (s >= 65281) return 8'd255;
        for (int n = 255; n > 0; n--) begin
            if (n * n - n < s) return n[7:0];
        end
        return 8'd0;
    endfunction

    // predicts the result (if any) of one accepted input item
    function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int    w, h, cr, cc, nr, nc, d, p, s;
        int    gx[3], gy[3];
        int    kx[3][3], ky[3][3];
        bit    emitted, last;
        bit [23:0] cur, v;
        t_edge e;
        kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
        ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
        w = clamp_dim(width_reg, sem_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, sem_pkg::MAX_HEIGHT);
        cur = (op == 1'b0) ? {r, g, b} : 24'd0;
        emitted = 0;
        if (col >= w) begin
            col = 0;
            row++;
        end
        if (row >= 2 || (row == 1 && col >= 1)) begin
            if (col >= 1) begin
                cr = row - 1;
                cc = col - 1;
            end else begin
                cr = row - 2;
                cc = w - 1;
            end
            gx = '{0, 0, 0};
            gy = '{0, 0, 0};
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    nr = cr + dr;
                    nc = cc + dc;
                    if (nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
                    d = (w + 1) - dr * w - dc;
                    if (d < 0 || d > HIST_N) continue;
                    v = (d == 0) ? cur : history[d - 1];
                    for (int ch = 0; ch < 3; ch++) begin
                        p = (v >> (16 - 8 * ch)) & 8'hff;
                        gx[ch] += p * kx[dr + 1][dc + 1];
                        gy[ch] += p * ky[dr + 1][dc + 1];
                    end
                end
            end
            e.red = rounded_root(gx[0] * gx[0] + gy[0] * gy[0]);
            e.green = rounded_root(gx[1] * gx[1] + gy[1] * gy[1]);
            e.blue = rounded_root(gx[2] * gx[2] + gy[2] * gy[2]);
            last = (cr == h - 1) && (cc == w - 1);
            e.last = last;
            expected_edges.push_back(e);
            emitted = 1;
            if (last) begin
                row = 0;
                col = 0;
            end else begin
                col++;
            end
        end else begin
            col++;
        end
        if (!emitted || row != 0 || col != 0) begin
            if (col >= w) begin
                col = 0;
                row++;
            end
        end
        for (int i = HIST_N - 1; i > 0; i--) history[i] = history[i - 1];
        history[0] = cur;
    endfunction

    task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
        t_edge e;
        results_seen++;
        if (expected_edges.size() == 0) begin
            report("result item with nothing expected");
            return;
        end
        e = expected_edges.pop_front();
        if (r !== e.red)
            report($sformatf("red_edge %0d, expected %0d", r, e.red));
        if (g !== e.green)
            report($sformatf("green_edge %0d, expected %0d", g, e.green));
        if (b !== e.blue)
            report($sformatf("blue_edge %0d, expected %0d", b, e.blue));
        if (last !== e.last)
            report($sformatf("last_pixel %0d, expected %0d", last, e.last));
    endtask

    function int pending();
        return expected_edges.size();
    endfunction
endclass

module sobel_edge_magnitude_rgb_top_test;

    localparam int IDLE_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n;

    sem_in_if  in_ch();
    sem_out_if out_ch();
    sem_cfg_if cfg_ch();

    sobel_edge_magnitude_rgb_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    edge_scoreboard edges = new();
    bit             fast_mode;
    int             items_sent, frames_sent, stall_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.operation = 1'b0;
        in_ch.red_in = '0;
        in_ch.green_in = '0;
        in_ch.blue_in = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = sem_pkg::REG_WIDTH;
        cfg_ch.data = '0;
    end

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // result side with random back-pressure
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = fast_mode ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            edges.check_result(out_ch.red_edge, out_ch.green_edge, out_ch.blue_edge,
                               out_ch.last_pixel);
        end
    end

    task send_pixel(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.red_in <= r;
        in_ch.green_in <= g;
        in_ch.blue_in <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        edges.note_input(op, r, g, b);
        items_sent++;
    endtask

    task drain_results();
        in_ch.valid <= 1'b0;
        while (edges.pending() > 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    // registers are only written with no item in flight
    task write_cfg(logic [sem_pkg::CFG_IDX_W-1:0] idx, logic [sem_pkg::DIM_W-1:0] data);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        edges.write_reg(idx, data);
    endtask

    function logic [7:0] pick_chan(int style);
        if (style == 1) return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // image pixels then flush items; a few strays of the other kind mixed in
    task send_frame(int w, int h, int style, int pause_at);
        int total;
        bit op;
        total = w * h + w + 1;
        for (int k = 0; k < total; k++) begin
            if (k == pause_at) drain_results();
            if (k < w * h) op = ($urandom_range(0, 15) == 0);
            else           op = ($urandom_range(0, 7) != 0);
            send_pixel(op, pick_chan(style), pick_chan(style), pick_chan(style));
        end
        frames_sent++;
    endtask

    initial begin
        int w, h, pause_at, n_stray;
        w = 1;
        h = 1;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed 3x3 frame: flat red, checkered green, blue edge at full scale,
        // one flush inside the image and one pixel among the flush items
        write_cfg(sem_pkg::REG_WIDTH, 11'd3);
        write_cfg(sem_pkg::REG_HEIGHT, 11'd3);
        for (int k = 0; k < 13; k++) begin
            if (k == 4)
                send_pixel(1'b1, 8'hff, 8'hff, 8'hff);
            else if (k < 9)
                send_pixel(1'b0, 8'hff, (k % 2) ? 8'hff : 8'h00, (k < 3) ? 8'hff : 8'h00);
            else
                send_pixel(k == 10 ? 1'b0 : 1'b1, 8'hff, 8'hff, 8'hff);
        end
        frames_sent++;
        drain_results();
        // unused register indexes change nothing
        write_cfg(sem_pkg::CFG_IDX_W'(2), 11'h7ff);
        write_cfg(sem_pkg::CFG_IDX_W'(3), 11'h555);
        write_cfg(sem_pkg::REG_WIDTH, 11'd1);
        write_cfg(sem_pkg::REG_HEIGHT, 11'd1);
        send_pixel(1'b0, 8'hff, 8'h00, 8'haa);
        send_pixel(1'b1, 8'h00, 8'hff, 8'h55);
        send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
        frames_sent++;
        drain_results();
        // zero sizes count as one
        write_cfg(sem_pkg::REG_WIDTH, 11'd0);
        write_cfg(sem_pkg::REG_HEIGHT, 11'd0);
        send_frame(1, 1, 1, -1);
        drain_results();

        // random frames, small sizes, some back to back without a new setting
        while (items_sent < 640) begin
            fast_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                write_cfg(sem_pkg::REG_WIDTH, sem_pkg::DIM_W'(w));
                write_cfg(sem_pkg::REG_HEIGHT, sem_pkg::DIM_W'(h));
            end
            pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h) : -1;
            send_frame(w, h, $urandom_range(0, 1), pause_at);
            if ($urandom_range(0, 9) == 0) begin
                // abandoned frame, restarted by a register write
                n_stray = $urandom_range(1, 2 * w + 3);
                for (int k = 0; k < n_stray; k++)
                    send_pixel(1'($urandom_range(0, 1)), pick_chan(0), pick_chan(0),
                               pick_chan(0));
                drain_results();
                write_cfg(sem_pkg::REG_HEIGHT, sem_pkg::DIM_W'(h));
            end
        end
        drain_results();

        // oversized height clamps; the start of a tall frame, then a restart
        fast_mode = 1'b0;
        write_cfg(sem_pkg::REG_WIDTH, 11'd2);
        write_cfg(sem_pkg::REG_HEIGHT, 11'h7ff);
        for (int k = 0; k < 40; k++)
            send_pixel(1'b0, pick_chan(0), pick_chan(0), pick_chan(0));
        drain_results();
        write_cfg(sem_pkg::REG_HEIGHT, 11'd1);
        drain_results();

        $display("covered %0d input items in %0d frames, %0d result items checked",
                 items_sent, frames_sent, edges.results_seen);
        $display("sizes from 1x1 to 12x8 and a tall frame, with random gaps and stalls");
        if (edges.errors == 0 && edges.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
